FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/tmal_pkg.sv
// ----------------------------------------------------------------------------
// tmal_pkg
// Types, codes and widths of the tile map attribute lookup block.
// ----------------------------------------------------------------------------
package tmal_pkg;

    // Default store depths in bytes.
    localparam int MAP_DEPTH_DEF  = 65536;
    localparam int ATTR_DEPTH_DEF = 4096;

    // A tile byte holds a column in its low nibble and a row in its high nibble.
    localparam int TILE_COL_BITS = 4;

    // Datapath widths.
    localparam int CFG_W      = 11;  // widest configuration register
    localparam int PROD_W     = 26;  // pos_y (15 bits) times map_width (11 bits)
    localparam int IDX_W      = 27;  // pos_x plus that product
    localparam int MAP_LIM_W  = 22;  // map_height times map_width
    localparam int ATTR_IDX_W = 18;  // attribute index and attribute limit

    // Request commands.
    typedef enum logic [1:0] {
        CMD_WR_MAP  = 2'd0,
        CMD_WR_ATTR = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_DEC     = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAP_WIDTH   = 2'd0,
        CFG_MAP_HEIGHT  = 2'd1,
        CFG_ATTR_WIDTH  = 2'd2,
        CFG_ATTR_HEIGHT = 2'd3
    } t_cfg_idx;

    // Input request.
    typedef struct packed {
        t_cmd               command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        write_address;
        logic [7:0]         write_value;
    } t_in_req;

    // Result request.
    typedef struct packed {
        logic signed [8:0] result_value;
        logic              in_range;
    } t_out_req;

endpackage

FILE: rtl/core/tile_map_attribute_lookup_top.sv
// ----------------------------------------------------------------------------
// tile_map_attribute_lookup_top
// Tile map and attribute table with write, query and decrement requests.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  request   in         i_in_valid/o_in_stall  t_in_req  (i_in)
//  result    out        o_out_valid/i_out_stall t_out_req (o_out)
//  config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// A write request is applied when it is accepted. A query or decrement outside
// the map passes accept, multiply, then add and range test. A decrement inside
// the map adds its tile read, and a query also the attribute read after it (not
// when the entry lies outside the table); the multiply and the two dependent reads set this order.
// Reset clears control and configuration only; the memories are not cleared.
// While a result waits under i_out_stall, the request that follows may be
// taken and runs until it has its own result ready.
//
`include "assert_macros.svh"

module tile_map_attribute_lookup_top #(
    parameter int MAP_DEPTH  = tmal_pkg::MAP_DEPTH_DEF,
    parameter int ATTR_DEPTH = tmal_pkg::ATTR_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tmal_pkg::t_in_req          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tmal_pkg::t_out_req         o_out,
    input  logic                       i_cfg_we,
    input  tmal_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [tmal_pkg::CFG_W-1:0] i_cfg_data
);

    import tmal_pkg::*;

    localparam int MAP_AW  = $clog2(MAP_DEPTH);
    localparam int ATTR_AW = $clog2(ATTR_DEPTH);

    logic               tile_we, tile_re;
    logic [MAP_AW-1:0]  tile_waddr, tile_raddr;
    logic [7:0]         tile_wdata, tile_rdata;
    logic               attr_we, attr_re;
    logic [ATTR_AW-1:0] attr_waddr, attr_raddr;
    logic [7:0]         attr_wdata, attr_rdata;

    // Sequencer and datapath.
    tmal_ctrl #(
        .MAP_DEPTH  (MAP_DEPTH),
        .ATTR_DEPTH (ATTR_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_tile_we    (tile_we),
        .o_tile_waddr (tile_waddr),
        .o_tile_wdata (tile_wdata),
        .o_tile_re    (tile_re),
        .o_tile_raddr (tile_raddr),
        .i_tile_rdata (tile_rdata),
        .o_attr_we    (attr_we),
        .o_attr_waddr (attr_waddr),
        .o_attr_wdata (attr_wdata),
        .o_attr_re    (attr_re),
        .o_attr_raddr (attr_raddr),
        .i_attr_rdata (attr_rdata)
    );

    // Tile map store.
    tmal_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (tile_we),
        .i_waddr (tile_waddr),
        .i_wdata (tile_wdata),
        .i_re    (tile_re),
        .i_raddr (tile_raddr),
        .o_rdata (tile_rdata)
    );

    // Attribute table store.
    tmal_ram #(
        .WIDTH (8),
        .DEPTH (ATTR_DEPTH)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (attr_we),
        .i_waddr (attr_waddr),
        .i_wdata (attr_wdata),
        .i_re    (attr_re),
        .i_raddr (attr_raddr),
        .o_rdata (attr_rdata)
    );

    // The tile store is never read and written in the same cycle.
    `ASSERT_IMP(a_tile_no_rw, i_clk, i_rst_n, tile_re, !tile_we)
    // A tile read leaves the block busy for the cycle that uses its data.
    `ASSERT_NEXT(a_tile_busy, i_clk, i_rst_n, tile_re, o_in_stall)
    // An attribute read leaves the block busy for the cycle that uses its data.
    `ASSERT_NEXT(a_attr_busy, i_clk, i_rst_n, attr_re, o_in_stall)
    // A new result only comes from a request that was in progress.
    `ASSERT_IMP(a_out_source, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

FILE: rtl/core/tmal_ram.sv
// ----------------------------------------------------------------------------
// tmal_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tmal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and a read register that holds its value between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tmal_ctrl.sv
// ----------------------------------------------------------------------------
// tmal_ctrl
// Sequencer and datapath: index arithmetic, range tests, memory accesses
// and the result register.
// ----------------------------------------------------------------------------
module tmal_ctrl #(
    parameter int MAP_DEPTH  = tmal_pkg::MAP_DEPTH_DEF,
    parameter int ATTR_DEPTH = tmal_pkg::ATTR_DEPTH_DEF,
    localparam int MAP_AW    = $clog2(MAP_DEPTH),
    localparam int ATTR_AW   = $clog2(ATTR_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tmal_pkg::t_in_req    i_in,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tmal_pkg::t_out_req   o_out,
    // Configuration writes
    input  logic                 i_cfg_we,
    input  tmal_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [tmal_pkg::CFG_W-1:0] i_cfg_data,
    // Tile memory
    output logic                 o_tile_we,
    output logic [MAP_AW-1:0]    o_tile_waddr,
    output logic [7:0]           o_tile_wdata,
    output logic                 o_tile_re,
    output logic [MAP_AW-1:0]    o_tile_raddr,
    input  logic [7:0]           i_tile_rdata,
    // Attribute memory
    output logic                 o_attr_we,
    output logic [ATTR_AW-1:0]   o_attr_waddr,
    output logic [7:0]           o_attr_wdata,
    output logic                 o_attr_re,
    output logic [ATTR_AW-1:0]   o_attr_raddr,
    input  logic [7:0]           i_attr_rdata
);

    import tmal_pkg::*;

    localparam logic [IDX_W-1:0]      MAP_LIM_C  = IDX_W'(MAP_DEPTH);
    localparam logic [ATTR_IDX_W-1:0] ATTR_LIM_C = ATTR_IDX_W'(ATTR_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_TILE,
        ST_ATTR
    } t_state;

    t_state r_state, n_state;

    // Configuration registers and the limits derived from them.
    logic [10:0]           r_map_w;
    logic [10:0]           r_map_h;
    logic [8:0]            r_attr_w;
    logic [8:0]            r_attr_h;
    logic [MAP_LIM_W-1:0]  r_map_lim;
    logic [ATTR_IDX_W-1:0] r_attr_lim;

    // Request being worked on.
    t_cmd                  r_cmd;
    logic signed [15:0]    r_x;
    logic signed [15:0]    r_y;
    logic [PROD_W-1:0]     r_prod;
    logic [IDX_W-1:0]      r_idx;

    // Result register.
    logic                  r_out_valid, n_out_valid;
    t_out_req              r_out, n_out;

    // Combinational helpers.
    logic                  out_free;
    logic [IDX_W-1:0]      idx;
    logic                  in_map;
    logic [12:0]           attr_prod;
    logic [ATTR_IDX_W-1:0] attr_idx;
    logic                  attr_ok;
    logic [IDX_W-1:0]      map_wa;
    logic [ATTR_IDX_W-1:0] attr_wa;
    logic [8:0]            tile_dec;

    assign out_free = !r_out_valid || !i_out_stall;

    // Linear map index and the map range test.
    assign idx    = IDX_W'(r_x[14:0]) + IDX_W'(r_prod);
    assign in_map = !r_x[15] && !r_y[15] && (idx < IDX_W'(r_map_lim)) && (idx < MAP_LIM_C);

    // Attribute index from the tile byte and its range test.
    assign attr_prod = 13'(r_attr_w) * 13'(i_tile_rdata[7:TILE_COL_BITS]);
    assign attr_idx  = ATTR_IDX_W'(attr_prod) + ATTR_IDX_W'(i_tile_rdata[TILE_COL_BITS-1:0]);
    assign attr_ok   = (attr_idx < r_attr_lim) && (attr_idx < ATTR_LIM_C);

    assign map_wa   = IDX_W'(i_in.write_address);
    assign attr_wa  = ATTR_IDX_W'(i_in.write_address);
    assign tile_dec = {1'b0, i_tile_rdata} - 9'd1;

    // Next state, memory strobes and result loading.
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        o_tile_we    = 1'b0;
        o_tile_waddr = map_wa[MAP_AW-1:0];
        o_tile_wdata = i_in.write_value;
        o_tile_re    = 1'b0;
        o_tile_raddr = idx[MAP_AW-1:0];
        o_attr_we    = 1'b0;
        o_attr_waddr = attr_wa[ATTR_AW-1:0];
        o_attr_wdata = i_in.write_value;
        o_attr_re    = 1'b0;
        o_attr_raddr = attr_idx[ATTR_AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.command)
                        CMD_WR_MAP: begin
                            o_tile_we = (map_wa < MAP_LIM_C);
                        end
                        CMD_WR_ATTR: begin
                            o_attr_we = (attr_wa < ATTR_LIM_C);
                        end
                        default: begin
                            n_state = ST_MUL;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (in_map) begin
                    o_tile_re = 1'b1;
                    n_state   = ST_TILE;
                end else if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = '0;
                    n_out.in_range     = 1'b0;
                    n_state            = ST_IDLE;
                end
            end
            ST_TILE: begin
                if (r_cmd == CMD_DEC) begin
                    // The write-back happens once, together with the result.
                    if (out_free) begin
                        o_tile_we          = 1'b1;
                        o_tile_waddr       = r_idx[MAP_AW-1:0];
                        o_tile_wdata       = tile_dec[7:0];
                        n_out_valid        = 1'b1;
                        n_out.result_value = $signed(tile_dec);
                        n_out.in_range     = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end else if (attr_ok) begin
                    o_attr_re = 1'b1;
                    n_state   = ST_ATTR;
                end else if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = '0;
                    n_out.in_range     = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            ST_ATTR: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = $signed({1'b0, i_attr_rdata});
                    n_out.in_range     = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, configuration, working registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_map_w     <= '0;
            r_map_h     <= '0;
            r_attr_w    <= '0;
            r_attr_h    <= '0;
            r_map_lim   <= '0;
            r_attr_lim  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAP_WIDTH:   r_map_w  <= i_cfg_data;
                    CFG_MAP_HEIGHT:  r_map_h  <= i_cfg_data;
                    CFG_ATTR_WIDTH:  r_attr_w <= i_cfg_data[8:0];
                    CFG_ATTR_HEIGHT: r_attr_h <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
            // Limits are registered from the configuration registers and follow them in the next cycle.
            r_map_lim  <= MAP_LIM_W'(r_map_h) * MAP_LIM_W'(r_map_w);
            r_attr_lim <= ATTR_IDX_W'(r_attr_h) * ATTR_IDX_W'(r_attr_w);
        end
        r_out <= n_out;
        if (r_state == ST_IDLE) begin
            r_cmd <= i_in.command;
            r_x   <= i_in.pos_x;
            r_y   <= i_in.pos_y;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_y[14:0]) * PROD_W'(r_map_w);
        end
        if (r_state == ST_CHK) begin
            r_idx <= idx;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: bench/tile_map_attribute_lookup_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_map_attribute_lookup_top_test
// Self-checking bench for the tile map attribute lookup block. It loads the
// tile map and the attribute table through write requests. It then issues
// queries and decrements on directed and random positions under several map
// and table layouts. Each answer is checked against a shadow copy of both
// stores, and both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module tile_map_attribute_lookup_top_test;
    import tmal_pkg::*;

    localparam int TILE_DEPTH       = MAP_DEPTH_DEF;
    localparam int ATTR_DEPTH       = ATTR_DEPTH_DEF;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int ITEMS_PER_LAYOUT = 32;
    localparam int NUM_LAYOUTS      = 9;

    // A request waiting to be offered, with the answer it must produce.
    typedef struct {
        t_in_req  req;
        bit       answers;
        t_out_req answer;
    } t_lookup_req;

    // Map width, map height, table width, table height for each random phase.
    int unsigned layouts [NUM_LAYOUTS][4] = '{
        '{1024, 1024, 256, 256},
        '{2047, 2047, 511, 511},
        '{1, 1, 1, 1},
        '{37, 5, 3, 20},
        '{100, 600, 0, 200},
        '{300, 200, 20, 0},
        '{0, 1024, 256, 256},
        '{64, 0, 16, 16},
        '{8, 8, 16, 16}
    };

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    t_in_req                  i_in        = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_req                 o_out;
    logic                     i_cfg_we    = 1'b0;
    t_cfg_idx                 i_cfg_idx   = CFG_MAP_WIDTH;
    logic [CFG_W-1:0]         i_cfg_data  = '0;

    // Shadow stores and registers of the block.
    logic [7:0]  tile_shadow [TILE_DEPTH];
    bit          tile_loaded [TILE_DEPTH];
    logic [7:0]  attr_shadow [ATTR_DEPTH];
    bit          attr_loaded [ATTR_DEPTH];
    logic [10:0] map_w  = '0;
    logic [10:0] map_h  = '0;
    logic [8:0]  attr_w = '0;
    logic [8:0]  attr_h = '0;

    t_lookup_req lookup_requests [$];
    t_out_req    expected_answers [$];
    t_lookup_req on_offer;
    t_out_req    want;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    tile_map_attribute_lookup_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Number of map tiles that a position may reach.
    function automatic longint map_limit();
        longint lim;
        lim = longint'(map_h) * longint'(map_w);
        return (lim < TILE_DEPTH) ? lim : TILE_DEPTH;
    endfunction

    // Linear tile index of a position; false when it lies outside the map.
    function automatic bit locate(input logic signed [15:0] x, input logic signed [15:0] y,
                                  output int unsigned idx);
        longint lin;
        idx = 0;
        if (x < 0 || y < 0) begin
            return 1'b0;
        end
        lin = longint'(x) + longint'(y) * longint'(map_w);
        if (lin >= map_limit()) begin
            return 1'b0;
        end
        idx = 32'(lin);
        return 1'b1;
    endfunction

    // Attribute entry that a tile selects; false when it lies outside the table.
    function automatic bit attr_index(input logic [7:0] tile, output int unsigned a);
        longint lim;
        a   = 32'(tile[3:0]) + 32'(attr_w) * 32'(tile[7:4]);
        lim = longint'(attr_h) * longint'(attr_w);
        return (a < lim) && (a < ATTR_DEPTH);
    endfunction

    // Applies one request to the shadow stores; returns whether it answers.
    function automatic bit predict_lookup(input t_in_req r, output t_out_req ans);
        int unsigned idx;
        int unsigned a;
        logic [7:0]  tile;
        ans = '0;
        case (r.command)
            CMD_WR_MAP: begin
                if (r.write_address < TILE_DEPTH) begin
                    tile_shadow[r.write_address] = r.write_value;
                    tile_loaded[r.write_address] = 1'b1;
                end
                return 1'b0;
            end
            CMD_WR_ATTR: begin
                if (r.write_address < ATTR_DEPTH) begin
                    attr_shadow[r.write_address] = r.write_value;
                    attr_loaded[r.write_address] = 1'b1;
                end
                return 1'b0;
            end
            default: begin
                if (locate(r.pos_x, r.pos_y, idx)) begin
                    tile         = tile_shadow[idx];
                    ans.in_range = 1'b1;
                    if (r.command == CMD_QUERY) begin
                        if (attr_index(tile, a)) begin
                            ans.result_value = {1'b0, attr_shadow[a]};
                        end
                    end else begin
                        // The decrement wraps a zero tile around to 255.
                        ans.result_value = {1'b0, tile} - 9'd1;
                        tile_shadow[idx] = tile - 8'd1;
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic t_in_req make_req(input t_cmd c, input logic signed [15:0] x,
                                         input logic signed [15:0] y, input logic [15:0] addr,
                                         input logic [7:0] val);
        t_in_req r;
        r.command       = c;
        r.pos_x         = x;
        r.pos_y         = y;
        r.write_address = addr;
        r.write_value   = val;
        return r;
    endfunction

    // Byte values biased toward the nibble and wrap boundaries.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            3:       return 8'h0F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void enqueue(input t_in_req r);
        t_lookup_req item;
        item.req     = r;
        item.answers = predict_lookup(r, item.answer);
        lookup_requests.push_back(item);
    endfunction

    // Queues a request, first loading any store entry it would read unwritten.
    function automatic void submit(input t_in_req r);
        int unsigned idx;
        int unsigned a;
        if ((r.command == CMD_QUERY || r.command == CMD_DEC) && locate(r.pos_x, r.pos_y, idx))
        begin
            if (!tile_loaded[idx]) begin
                enqueue(make_req(CMD_WR_MAP, 16'($urandom), 16'($urandom), idx[15:0],
                                 pick_byte()));
            end
            if (r.command == CMD_QUERY && attr_index(tile_shadow[idx], a) && !attr_loaded[a])
            begin
                enqueue(make_req(CMD_WR_ATTR, 16'($urandom), 16'($urandom), a[15:0],
                                 pick_byte()));
            end
        end
        enqueue(r);
    endfunction

    // One random request: mostly positions inside the map, the rest writes and
    // positions that fall outside it.
    function automatic void random_request();
        t_in_req     r;
        longint      lim;
        longint      w;
        longint      idx;
        longint      hi;
        longint      lo;
        longint      yv;
        int unsigned pick;
        r    = make_req(t_cmd'($urandom_range(3, 0)), 16'($urandom), 16'($urandom),
                        16'($urandom), 8'($urandom));
        lim  = map_limit();
        w    = longint'(map_w);
        pick = $urandom_range(99, 0);
        if (pick >= 65 && pick < 75) begin
            r.command = CMD_WR_MAP;
            if ($urandom_range(1, 0) == 1) begin
                r.write_address = 16'($urandom_range(15, 0));
            end
            r.write_value = pick_byte();
        end else if (pick >= 75 && pick < 82) begin
            // Addresses past the table end are ignored by the block.
            r.command     = CMD_WR_ATTR;
            r.write_value = pick_byte();
        end else if (pick < 65 && lim > 0) begin
            // Inside the map, often on a few hot tiles, sometimes on the last.
            r.command = (pick < 40) ? CMD_QUERY : CMD_DEC;
            case ($urandom_range(7, 0))
                0, 1, 2: idx = longint'($urandom_range(32'((lim > 16) ? 15 : lim - 1), 0));
                3:       idx = lim - 1;
                default: idx = longint'($urandom_range(32'(lim - 1), 0));
            endcase
            hi = idx / w;
            if (hi > 32767) begin
                hi = 32767;
            end
            lo = (idx > 32767) ? (idx - 32767 + w - 1) / w : 0;
            // A row below the last one puts the column past the row end.
            yv = ($urandom_range(1, 0) == 1) ? hi : longint'($urandom_range(32'(hi), 32'(lo)));
            r.pos_y = 16'(yv);
            r.pos_x = 16'(idx - yv * w);
        end else begin
            r.command = ($urandom_range(1, 0) == 1) ? CMD_QUERY : CMD_DEC;
            case ($urandom_range(3, 0))
                0: begin
                end
                1: begin
                    r.pos_x[15] = 1'b1;
                    r.pos_y[15] = 1'b0;
                end
                2: begin
                    r.pos_x[15] = 1'b0;
                    r.pos_y[15] = 1'b1;
                end
                default: begin
                    // Just past the last tile of the map.
                    if (lim <= 32767 || w == 0) begin
                        r.pos_x = 16'(lim);
                        r.pos_y = '0;
                    end else begin
                        r.pos_x = '0;
                        r.pos_y = 16'((lim + w - 1) / w);
                    end
                end
            endcase
        end
        submit(r);
    endfunction

    function automatic bit work_outstanding();
        return lookup_requests.size() != 0 || i_in_valid || expected_answers.size() != 0;
    endfunction

    // Waits until every answer is in and the last write has settled.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (work_outstanding());
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx r, input int unsigned v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v[10:0];
        case (r)
            CFG_MAP_WIDTH:  map_w  = v[10:0];
            CFG_MAP_HEIGHT: map_h  = v[10:0];
            CFG_ATTR_WIDTH: attr_w = v[8:0];
            default:        attr_h = v[8:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_layout(input int unsigned mw, input int unsigned mh,
                              input int unsigned aw, input int unsigned ah);
        write_register(CFG_MAP_WIDTH, mw);
        write_register(CFG_MAP_HEIGHT, mh);
        write_register(CFG_ATTR_WIDTH, aw);
        write_register(CFG_ATTR_HEIGHT, ah);
    endtask

    // Request driver: offers queued requests and releases each answer when taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall && on_offer.answers) begin
                expected_answers.push_back(on_offer.answer);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (lookup_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    on_offer = lookup_requests.pop_front();
                    i_in_valid <= 1'b1;
                    i_in       <= on_offer.req;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each taken result against the oldest answer due.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    $error("unexpected result: result_value %0d, in_range %0b",
                           o_out.result_value, o_out.in_range);
                    mismatches++;
                end else begin
                    want = expected_answers.pop_front();
                    if (o_out.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, o_out.result_value);
                        mismatches++;
                    end
                    if (o_out.in_range !== want.in_range) begin
                        $error("in_range: expected %0b, got %0b",
                               want.in_range, o_out.in_range);
                        mismatches++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Watchdog: ends the run when outstanding work stops moving.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !work_outstanding())
        begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** tile_map_attribute_lookup_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With all registers at reset the map is empty, so nothing is in the map.
        submit(make_req(CMD_QUERY, 0, 0, 0, 0));
        submit(make_req(CMD_DEC, 0, 0, 0, 0));
        submit(make_req(CMD_QUERY, 5, 3, 16'hFFFF, 8'hFF));
        wait_drained();

        // A 16 by 16 map over a table of 16 by 8 entries.
        set_layout(16, 16, 16, 8);
        submit(make_req(CMD_WR_MAP, 0, 0, 16'd0, 8'h00));
        submit(make_req(CMD_WR_ATTR, 0, 0, 16'd0, 8'h5A));
        // Table writes past its end must not alias onto entry zero.
        submit(make_req(CMD_WR_ATTR, 0, 0, 16'd4096, 8'hA5));
        submit(make_req(CMD_WR_ATTR, 0, 0, 16'hFFFF, 8'hFF));
        submit(make_req(CMD_QUERY, 0, 0, 0, 0));
        // Decrement of a zero tile wraps it to 255, whose entry is past the table.
        submit(make_req(CMD_DEC, 0, 0, 0, 0));
        submit(make_req(CMD_QUERY, 0, 0, 0, 0));
        submit(make_req(CMD_DEC, 0, 0, 0, 0));
        submit(make_req(CMD_WR_MAP, 0, 0, 16'd255, 8'h17));
        submit(make_req(CMD_WR_ATTR, 0, 0, 16'd23, 8'hFF));
        submit(make_req(CMD_QUERY, 15, 15, 0, 0));
        // A column past the row end reaches the same last tile.
        submit(make_req(CMD_QUERY, 255, 0, 0, 0));
        submit(make_req(CMD_QUERY, 0, 16, 0, 0));
        submit(make_req(CMD_QUERY, -1, 0, 0, 0));
        submit(make_req(CMD_DEC, 32767, 32767, 0, 0));
        submit(make_req(CMD_DEC, -32768, -1, 0, 0));
        submit(make_req(CMD_WR_MAP, 0, 0, 16'hFFFF, 8'h80));
        submit(make_req(CMD_WR_MAP, 0, 0, 16'd1, 8'h7F));
        submit(make_req(CMD_WR_ATTR, 0, 0, 16'd127, 8'h01));
        submit(make_req(CMD_QUERY, 1, 0, 0, 0));
        submit(make_req(CMD_DEC, 1, 0, 0, 0));
        submit(make_req(CMD_QUERY, 1, 0, 0, 0));
        wait_drained();

        // Random phases, each with its own layout and throttling.
        for (int p = 0; p < NUM_LAYOUTS; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 57;
                end
                default: begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            set_layout(layouts[p][0], layouts[p][1], layouts[p][2], layouts[p][3]);
            repeat (ITEMS_PER_LAYOUT) random_request();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("** tile_map_attribute_lookup_top: PASSED **");
        end else begin
            $display("** tile_map_attribute_lookup_top: FAILED **");
        end
        $finish;
    end

endmodule
